/* sv/timestamped_snapshot_interpolator_assert.svh */
// Assertion macros for the snapshot interpolator.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef TIMESTAMPED_SNAPSHOT_INTERPOLATOR_ASSERT_SVH
`define TIMESTAMPED_SNAPSHOT_INTERPOLATOR_ASSERT_SVH

// same-cycle implication
`define TSI_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("snapshot interpolator check failed");

// next-cycle implication
`define TSI_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("snapshot interpolator check failed");

`endif

/* sv/tsi_pkg.sv */
// Shared types and constants for the snapshot interpolator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tsi_pkg;

   localparam int TICK_W      = 32;
   localparam int POS_W       = 32;
   localparam int AUX_W       = 16;
   localparam int LIMIT_W     = 4;
   localparam int FRAC_W      = 65;
   localparam int ACC_W       = 97;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic                    opcode;
      logic [TICK_W-1:0]       tick;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic                    active;
      logic [AUX_W-1:0]        aux_value;
      logic                    last_entity;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic [TICK_W-1:0]       out_tick;
      logic signed [POS_W-1:0] out_x;
      logic signed [POS_W-1:0] out_y;
      logic                    out_active;
      logic [AUX_W-1:0]        out_aux;
      logic                    last_result;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic             flag;
      logic [AUX_W-1:0] aux;
   } ent_rec_type;

   typedef struct packed {
      logic valid;
      logic kind;
   } queue_head_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* sv/tsi_front.sv */
// Front end: accepts request transactions, tags load or query, queues them.
// Depends on tsi_pkg.
`timescale 1ns / 1ps

module tsi_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  tsi_pkg::req_type        req_data,
   input  logic                    pop,
   output tsi_pkg::queue_head_type head,
   output tsi_pkg::req_type        head_data
);

   typedef struct packed {
      logic             kind;
      tsi_pkg::req_type req;
   } entry_type;

   entry_type                       entry_ff [tsi_pkg::QUEUE_DEPTH];
   logic [tsi_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tsi_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tsi_pkg::QPTR_W:0]        cnt_ff, cnt_in;
   logic                            push;

   assign req_stall  = (cnt_ff == (tsi_pkg::QPTR_W+1)'(tsi_pkg::QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign head.valid = (cnt_ff != '0);
   assign head.kind  = entry_ff[rd_ptr_ff].kind;
   assign head_data  = entry_ff[rd_ptr_ff].req;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff].kind <= req_data.opcode ? tsi_pkg::KIND_QUERY : tsi_pkg::KIND_LOAD;
         entry_ff[wr_ptr_ff].req  <= req_data;
      end
   end

endmodule

/* sv/tsi_div.sv */
// Serial fraction unit: ceil(num * 2^65 / dt) for num <= dt, one bit a cycle.
// Depends on tsi_pkg.
`timescale 1ns / 1ps

module tsi_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tsi_pkg::TICK_W-1:0]    num,
   input  logic [tsi_pkg::TICK_W-1:0]    dt,
   output tsi_pkg::div_status_type       status,
   output logic [tsi_pkg::FRAC_W-1:0]    quotient
);

   localparam int CNT_W = $clog2(tsi_pkg::FRAC_W + 1);

   logic [tsi_pkg::TICK_W-1:0] rem_ff, rem_in;
   logic [tsi_pkg::TICK_W-1:0] dt_ff, dt_in;
   logic [tsi_pkg::FRAC_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [tsi_pkg::TICK_W:0]   rem2;
   logic                       ge;

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

   always_comb begin
      rem2    = {rem_ff, 1'b0};
      ge      = (rem2 >= {1'b0, dt_ff});
      rem_in  = rem_ff;
      dt_in   = dt_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = num;
         dt_in   = dt;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (cnt_ff != CNT_W'(tsi_pkg::FRAC_W)) begin
            rem_in = ge ? tsi_pkg::TICK_W'(rem2 - {1'b0, dt_ff}) : rem2[tsi_pkg::TICK_W-1:0];
            quo_in = {quo_ff[tsi_pkg::FRAC_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
         end else begin
            // round up when inexact; num equal to dt holds at all ones
            quo_in  = quo_ff + tsi_pkg::FRAC_W'((rem_ff != '0) && !(&quo_ff));
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dt_ff  <= dt_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

endmodule

/* sv/tsi_back.sv */
// Back end: snapshot store, loading, query search and interpolation sequencer.
// Depends on tsi_pkg; uses the fraction from tsi_div.
`timescale 1ns / 1ps

module tsi_back #(
   parameter int HISTORY_DEPTH = 8,
   parameter int ENTITY_COUNT  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tsi_pkg::LIMIT_W-1:0]   history_limit,
   input  tsi_pkg::queue_head_type       head,
   input  tsi_pkg::req_type              head_data,
   output logic                          pop,
   output logic                          div_start,
   output logic [tsi_pkg::TICK_W-1:0]    div_num,
   output logic [tsi_pkg::TICK_W-1:0]    div_dt,
   input  tsi_pkg::div_status_type       div_stat,
   input  logic [tsi_pkg::FRAC_W-1:0]    div_quo,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tsi_pkg::rsp_type              rsp_data
);

   localparam int SLOTS     = HISTORY_DEPTH + 1;
   localparam int SW        = $clog2(SLOTS);
   localparam int EW        = (ENTITY_COUNT > 1) ? $clog2(ENTITY_COUNT) : 1;
   localparam int AW        = SW + EW;
   localparam int MEM_DEPTH = SLOTS << EW;
   localparam int CMP_W     = ((SW > tsi_pkg::LIMIT_W) ? SW : tsi_pkg::LIMIT_W) + 1;
   localparam int PW        = tsi_pkg::POS_W;

   localparam logic [EW-1:0] LAST_ENT  = EW'(ENTITY_COUNT - 1);
   localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_FILL   = 4'd1;
   localparam logic [3:0] ST_EMPTY  = 4'd2;
   localparam logic [3:0] ST_QFIRST = 4'd3;
   localparam logic [3:0] ST_QLAST  = 4'd4;
   localparam logic [3:0] ST_QSCAN  = 4'd5;
   localparam logic [3:0] ST_DIV    = 4'd6;
   localparam logic [3:0] ST_IRD    = 4'd7;
   localparam logic [3:0] ST_IPREP  = 4'd8;
   localparam logic [3:0] ST_IM0    = 4'd9;
   localparam logic [3:0] ST_IM1    = 4'd10;
   localparam logic [3:0] ST_IM2    = 4'd11;
   localparam logic [3:0] ST_IRND   = 4'd12;
   localparam logic [3:0] ST_IOUT   = 4'd13;
   localparam logic [3:0] ST_EREAD  = 4'd14;
   localparam logic [3:0] ST_EOUT   = 4'd15;

   function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
      logic [SW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (SW+1)'(SLOTS)) begin
         s = s - (SW+1)'(SLOTS);
      end
      return s[SW-1:0];
   endfunction

   function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] a);
      return (a == LAST_SLOT) ? '0 : a + 1'b1;
   endfunction

   tsi_pkg::ent_rec_type ent_mem [MEM_DEPTH];
   logic [tsi_pkg::TICK_W-1:0] tick_mem [SLOTS];

   logic [3:0]                 state_ff, state_in;
   logic [SW-1:0]              count_ff, count_in;
   logic [SW-1:0]              oldest_ff, oldest_in;
   logic [EW-1:0]              load_idx_ff, load_idx_in;
   logic                       disc_ff, disc_in;
   logic [EW-1:0]              ent_ff, ent_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   tsi_pkg::rsp_type           rsp_ff, rsp_in;

   logic [tsi_pkg::TICK_W-1:0] stage_tick_ff, stage_tick_in;
   logic [tsi_pkg::TICK_W-1:0] newest_tick_ff, newest_tick_in;
   logic [tsi_pkg::TICK_W-1:0] qtick_ff, qtick_in;
   logic [tsi_pkg::TICK_W-1:0] prev_ff, prev_in;
   logic [tsi_pkg::TICK_W-1:0] emit_tick_ff, emit_tick_in;
   logic [SW-1:0]              emit_slot_ff, emit_slot_in;
   logic [SW-1:0]              sa_ff, sa_in;
   logic [SW-1:0]              sb_ff, sb_in;
   logic [PW-1:0]              va_x_ff, va_x_in, va_y_ff, va_y_in;
   logic [PW-1:0]              mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic                       neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [tsi_pkg::ACC_W-1:0]  acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic [PW-1:0]              q_x_ff, q_x_in, q_y_ff, q_y_in;
   logic                       flag_ff, flag_in;
   logic [tsi_pkg::AUX_W-1:0]  aux_ff, aux_in;

   tsi_pkg::ent_rec_type       rd_a_ff, rd_b_ff;
   logic [tsi_pkg::TICK_W-1:0] tick_rd_ff;

   logic                       ent_we;
   logic [AW-1:0]              ent_waddr, ent_raddr_a, ent_raddr_b;
   tsi_pkg::ent_rec_type       ent_wdata;
   logic                       tick_we;
   logic [SW-1:0]              tick_raddr;

   logic [SW-1:0]              stage_slot, newest_slot, lim, evict_n;
   logic [CMP_W-1:0]           hl_ext;
   logic                       out_free;
   logic [31:0]                mul_op;
   logic [63:0]                prod_x, prod_y;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign div_num   = qtick_ff - prev_ff;
   assign div_dt    = tick_rd_ff - prev_ff;

   assign stage_slot  = slot_add(oldest_ff, count_ff);
   assign newest_slot = slot_add(oldest_ff, count_ff - 1'b1);
   assign evict_n     = count_ff - lim + 1'b1;

   always_comb begin
      hl_ext = CMP_W'(history_limit);
      if (hl_ext == '0) begin
         lim = SW'(1);
      end else if (hl_ext > CMP_W'(HISTORY_DEPTH)) begin
         lim = SW'(HISTORY_DEPTH);
      end else begin
         lim = hl_ext[SW-1:0];
      end
   end

   assign ent_raddr_a = {((state_ff == ST_EREAD) || (state_ff == ST_EOUT)) ? emit_slot_ff : sa_ff,
                         ent_ff};
   assign ent_raddr_b = {sb_ff, ent_ff};

   assign mul_op = (state_ff == ST_IM0) ? div_quo[31:0] : div_quo[63:32];
   assign prod_x = mag_x_ff * mul_op;
   assign prod_y = mag_y_ff * mul_op;

   always_comb begin
      logic                       first;
      logic                       disc;
      logic [tsi_pkg::TICK_W-1:0] stick;
      logic                       do_commit;
      logic [tsi_pkg::TICK_W-1:0] commit_tick;
      logic [PW:0]                dx, dy, mx, my;
      logic [tsi_pkg::ACC_W:0]    rx, ry;

      first       = (load_idx_ff == '0);
      disc        = disc_ff;
      stick       = stage_tick_ff;
      do_commit   = 1'b0;
      commit_tick = stage_tick_ff;
      dx          = '0;
      dy          = '0;
      mx          = '0;
      my          = '0;
      rx          = '0;
      ry          = '0;

      state_in       = state_ff;
      count_in       = count_ff;
      oldest_in      = oldest_ff;
      load_idx_in    = load_idx_ff;
      disc_in        = disc_ff;
      ent_in         = ent_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      stage_tick_in  = stage_tick_ff;
      newest_tick_in = newest_tick_ff;
      qtick_in       = qtick_ff;
      prev_in        = prev_ff;
      emit_tick_in   = emit_tick_ff;
      emit_slot_in   = emit_slot_ff;
      sa_in          = sa_ff;
      sb_in          = sb_ff;
      va_x_in        = va_x_ff;
      va_y_in        = va_y_ff;
      mag_x_in       = mag_x_ff;
      mag_y_in       = mag_y_ff;
      neg_x_in       = neg_x_ff;
      neg_y_in       = neg_y_ff;
      acc_x_in       = acc_x_ff;
      acc_y_in       = acc_y_ff;
      q_x_in         = q_x_ff;
      q_y_in         = q_y_ff;
      flag_in        = flag_ff;
      aux_in         = aux_ff;

      pop        = 1'b0;
      div_start  = 1'b0;
      ent_we     = 1'b0;
      ent_waddr  = {stage_slot, ent_ff};
      ent_wdata  = '0;
      tick_we    = 1'b0;
      tick_raddr = oldest_ff;

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.kind == tsi_pkg::KIND_QUERY) begin
                  qtick_in = head_data.tick;
                  state_in = (count_ff == '0) ? ST_EMPTY : ST_QFIRST;
               end else begin
                  if (first) begin
                     stick = head_data.tick;
                     disc  = (count_ff != '0) && (head_data.tick <= newest_tick_ff);
                  end
                  stage_tick_in  = stick;
                  ent_we         = 1'b1;
                  ent_waddr      = {stage_slot, load_idx_ff};
                  ent_wdata.x    = head_data.pos_x;
                  ent_wdata.y    = head_data.pos_y;
                  ent_wdata.flag = head_data.active;
                  ent_wdata.aux  = head_data.aux_value;
                  if (head_data.last_entity || (load_idx_ff == LAST_ENT)) begin
                     load_idx_in = '0;
                     disc_in     = 1'b0;
                     if (!disc) begin
                        if (load_idx_ff == LAST_ENT) begin
                           do_commit   = 1'b1;
                           commit_tick = stick;
                        end else begin
                           // entities never loaded must read as zero
                           ent_in   = load_idx_ff + 1'b1;
                           state_in = ST_FILL;
                        end
                     end
                  end else begin
                     load_idx_in = load_idx_ff + 1'b1;
                     disc_in     = disc;
                  end
               end
            end
         end
         ST_FILL: begin
            ent_we = 1'b1;
            if (ent_ff == LAST_ENT) begin
               do_commit = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               ent_in = ent_ff + 1'b1;
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = '0;
               rsp_in.last_result = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         ST_QFIRST: begin
            prev_in = tick_rd_ff;
            if (qtick_ff <= tick_rd_ff) begin
               emit_slot_in = oldest_ff;
               emit_tick_in = tick_rd_ff;
               ent_in       = '0;
               state_in     = ST_EREAD;
            end else begin
               tick_raddr = newest_slot;
               state_in   = ST_QLAST;
            end
         end
         ST_QLAST: begin
            if (qtick_ff >= tick_rd_ff) begin
               emit_slot_in = newest_slot;
               emit_tick_in = tick_rd_ff;
               ent_in       = '0;
               state_in     = ST_EREAD;
            end else begin
               sa_in      = oldest_ff;
               sb_in      = slot_inc(oldest_ff);
               tick_raddr = slot_inc(oldest_ff);
               state_in   = ST_QSCAN;
            end
         end
         ST_QSCAN: begin
            if (tick_rd_ff < qtick_ff) begin
               prev_in    = tick_rd_ff;
               sa_in      = sb_ff;
               sb_in      = slot_inc(sb_ff);
               tick_raddr = slot_inc(sb_ff);
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               ent_in   = '0;
               state_in = ST_IRD;
            end
         end
         ST_IRD: begin
            state_in = ST_IPREP;
         end
         ST_IPREP: begin
            dx       = {rd_b_ff.x[PW-1], rd_b_ff.x} - {rd_a_ff.x[PW-1], rd_a_ff.x};
            dy       = {rd_b_ff.y[PW-1], rd_b_ff.y} - {rd_a_ff.y[PW-1], rd_a_ff.y};
            mx       = dx[PW] ? (~dx + 1'b1) : dx;
            my       = dy[PW] ? (~dy + 1'b1) : dy;
            va_x_in  = rd_a_ff.x;
            va_y_in  = rd_a_ff.y;
            neg_x_in = dx[PW];
            neg_y_in = dy[PW];
            mag_x_in = mx[PW-1:0];
            mag_y_in = my[PW-1:0];
            flag_in  = rd_a_ff.flag & rd_b_ff.flag;
            aux_in   = rd_a_ff.aux;
            state_in = ST_IM0;
         end
         ST_IM0: begin
            acc_x_in = tsi_pkg::ACC_W'(prod_x);
            acc_y_in = tsi_pkg::ACC_W'(prod_y);
            state_in = ST_IM1;
         end
         ST_IM1: begin
            acc_x_in = acc_x_ff + {1'b0, prod_x, 32'b0};
            acc_y_in = acc_y_ff + {1'b0, prod_y, 32'b0};
            state_in = ST_IM2;
         end
         ST_IM2: begin
            if (div_quo[64]) begin
               acc_x_in = acc_x_ff + {1'b0, mag_x_ff, 64'b0};
               acc_y_in = acc_y_ff + {1'b0, mag_y_ff, 64'b0};
            end
            state_in = ST_IRND;
         end
         ST_IRND: begin
            rx       = {1'b0, acc_x_ff} + {1'b0, 1'b0, 1'b1, 64'b0};
            ry       = {1'b0, acc_y_ff} + {1'b0, 1'b0, 1'b1, 64'b0};
            q_x_in   = rx[96:65];
            q_y_in   = ry[96:65];
            state_in = ST_IOUT;
         end
         ST_IOUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.found       = 1'b1;
               rsp_in.out_tick    = qtick_ff;
               rsp_in.out_x       = neg_x_ff ? va_x_ff - q_x_ff : va_x_ff + q_x_ff;
               rsp_in.out_y       = neg_y_ff ? va_y_ff - q_y_ff : va_y_ff + q_y_ff;
               rsp_in.out_active  = flag_ff;
               rsp_in.out_aux     = aux_ff;
               rsp_in.last_result = (ent_ff == LAST_ENT);
               if (ent_ff == LAST_ENT) begin
                  state_in = ST_IDLE;
               end else begin
                  ent_in   = ent_ff + 1'b1;
                  state_in = ST_IRD;
               end
            end
         end
         ST_EREAD: begin
            state_in = ST_EOUT;
         end
         ST_EOUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.found       = 1'b1;
               rsp_in.out_tick    = emit_tick_ff;
               rsp_in.out_x       = rd_a_ff.x;
               rsp_in.out_y       = rd_a_ff.y;
               rsp_in.out_active  = rd_a_ff.flag;
               rsp_in.out_aux     = rd_a_ff.aux;
               rsp_in.last_result = (ent_ff == LAST_ENT);
               if (ent_ff == LAST_ENT) begin
                  state_in = ST_IDLE;
               end else begin
                  ent_in   = ent_ff + 1'b1;
                  state_in = ST_EREAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // the staging slot stays put across eviction, so commit is a pointer update
      if (do_commit) begin
         tick_we        = 1'b1;
         newest_tick_in = commit_tick;
         if (count_ff >= lim) begin
            oldest_in = slot_add(oldest_ff, evict_n);
            count_in  = lim;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         oldest_ff    <= '0;
         load_idx_ff  <= '0;
         disc_ff      <= 1'b0;
         ent_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         load_idx_ff  <= load_idx_in;
         disc_ff      <= disc_in;
         ent_ff       <= ent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff         <= rsp_in;
      stage_tick_ff  <= stage_tick_in;
      newest_tick_ff <= newest_tick_in;
      qtick_ff       <= qtick_in;
      prev_ff        <= prev_in;
      emit_tick_ff   <= emit_tick_in;
      emit_slot_ff   <= emit_slot_in;
      sa_ff          <= sa_in;
      sb_ff          <= sb_in;
      va_x_ff        <= va_x_in;
      va_y_ff        <= va_y_in;
      mag_x_ff       <= mag_x_in;
      mag_y_ff       <= mag_y_in;
      neg_x_ff       <= neg_x_in;
      neg_y_ff       <= neg_y_in;
      acc_x_ff       <= acc_x_in;
      acc_y_ff       <= acc_y_in;
      q_x_ff         <= q_x_in;
      q_y_ff         <= q_y_in;
      flag_ff        <= flag_in;
      aux_ff         <= aux_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_waddr] <= ent_wdata;
      end
      rd_a_ff <= ent_mem[ent_raddr_a];
      rd_b_ff <= ent_mem[ent_raddr_b];
   end

   always_ff @(posedge clock) begin
      if (tick_we) begin
         tick_mem[stage_slot] <= newest_tick_in;
      end
      tick_rd_ff <= tick_mem[tick_raddr];
   end

endmodule

/* sv/timestamped_snapshot_interpolator.sv */
// Top level of the snapshot interpolator: front queue, back sequencer, fraction unit.
// Depends on tsi_pkg, tsi_front, tsi_back, tsi_div and the assertion macro header.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | tsi_pkg::req_type
//   rsp     | out       | rsp_valid/stall    | tsi_pkg::rsp_type
//   csr     | in        | csr_valid/ready    | history_limit, 4 bits
//
// Loads retire one a cycle while the back end is idle; a snapshot closed early has its
// missing entities filled with zero. A query answered by an end snapshot reads each entity
// in turn; an interpolated one runs the 65-step serial fraction unit and then the 7-step
// per-entity lerp sequence.
// Synchronous reset; no clearing pass over the stores. A four-deep queue keeps
// requests flowing while results stall; the result register holds under rsp_stall.
`timescale 1ns / 1ps

`include "timestamped_snapshot_interpolator_assert.svh"

module timestamped_snapshot_interpolator #(
   parameter int HISTORY_DEPTH = 8,
   parameter int PLAYER_COUNT  = 4,
   parameter int COIN_COUNT    = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tsi_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tsi_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tsi_pkg::LIMIT_W-1:0]   csr_data
);

   localparam int ENTITY_COUNT = PLAYER_COUNT + COIN_COUNT;

   logic [tsi_pkg::LIMIT_W-1:0] history_limit_ff, history_limit_in;
   tsi_pkg::queue_head_type     head;
   tsi_pkg::req_type            head_data;
   logic                        pop;
   logic                        div_start;
   logic [tsi_pkg::TICK_W-1:0]  div_num, div_dt;
   tsi_pkg::div_status_type     div_stat;
   logic [tsi_pkg::FRAC_W-1:0]  div_quo;

   assign csr_ready        = 1'b1;
   assign history_limit_in = (csr_valid && csr_ready) ? csr_data : history_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         history_limit_ff <= tsi_pkg::LIMIT_RESET;
      end else begin
         history_limit_ff <= history_limit_in;
      end
   end

   tsi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .pop       (pop),
      .head      (head),
      .head_data (head_data)
   );

   tsi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .dt       (div_dt),
      .status   (div_stat),
      .quotient (div_quo)
   );

   tsi_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .ENTITY_COUNT  (ENTITY_COUNT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .history_limit (history_limit_ff),
      .head          (head),
      .head_data     (head_data),
      .pop           (pop),
      .div_start     (div_start),
      .div_num       (div_num),
      .div_dt        (div_dt),
      .div_stat      (div_stat),
      .div_quo       (div_quo),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

   `TSI_ASSERT_NOW(a_pop_needs_head, pop, head.valid)
   `TSI_ASSERT_NOW(a_start_when_free, div_start, !div_stat.busy)
   `TSI_ASSERT_NEXT(a_start_goes_busy, div_start, div_stat.busy && !div_stat.done)
   `TSI_ASSERT_NOW(a_empty_answer, rsp_valid && !rsp_data.found, rsp_data.last_result && rsp_data.out_tick == '0)

endmodule

/* tb/timestamped_snapshot_interpolator_test.sv */
// Self-checking testbench for timestamped_snapshot_interpolator.
// Depends on tsi_pkg and the block; uses a built-in predictor and table-driven plus random stimulus.
`timescale 1ns / 1ps

module timestamped_snapshot_interpolator_test;

   localparam int DEPTH = 8;
   localparam int ENT   = 16;
   localparam int CYCLE_LIMIT = 900000;
   localparam int EXP_DEPTH = 1024;

   typedef struct {
      tsi_pkg::req_type r;
      bit               typed;
      tsi_pkg::rsp_type e;
   } stim_row_type;

   logic             clock, reset;
   logic             req_valid, req_stall;
   tsi_pkg::req_type req_data;
   logic             rsp_valid, rsp_stall;
   tsi_pkg::rsp_type rsp_data;
   logic             csr_valid, csr_ready;
   logic [tsi_pkg::LIMIT_W-1:0] csr_data;

   timestamped_snapshot_interpolator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // predictor state
   logic [3:0]  lim_reg;
   logic [31:0] snap_tick [DEPTH];
   logic [31:0] snap_x [DEPTH][ENT];
   logic [31:0] snap_y [DEPTH][ENT];
   logic        snap_flag [DEPTH][ENT];
   logic [15:0] snap_aux [DEPTH][ENT];
   int          oldest, count, load_idx;
   bit          discarding;
   logic [31:0] stg_tick;
   logic [31:0] stg_x [ENT];
   logic [31:0] stg_y [ENT];
   logic        stg_flag [ENT];
   logic [15:0] stg_aux [ENT];

   tsi_pkg::rsp_type exp_mem [EXP_DEPTH];
   int exp_wr, exp_rd;
   int errors, cycles, n_loads, n_queries, n_results, n_commits, n_interp;
   bit idle_on;
   int stall_left;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic void add_answer(tsi_pkg::rsp_type e);
      exp_mem[exp_wr % EXP_DEPTH] = e;
      exp_wr++;
   endfunction

   always @(posedge clock) begin
      tsi_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (exp_wr == exp_rd) begin
            errors++;
            if (errors <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            e = exp_mem[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_data.found !== e.found || rsp_data.out_tick !== e.out_tick ||
                rsp_data.out_x !== e.out_x || rsp_data.out_y !== e.out_y ||
                rsp_data.out_active !== e.out_active || rsp_data.out_aux !== e.out_aux ||
                rsp_data.last_result !== e.last_result) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: expected %p actual %p", e, rsp_data);
            end
         end
      end
   end

   function automatic int slot(int pos);
      return (oldest + pos) % DEPTH;
   endfunction

   function automatic logic [31:0] newest_tick();
      return count > 0 ? snap_tick[slot(count - 1)] : 32'd0;
   endfunction

   function automatic logic [31:0] lerp(logic [31:0] a, logic [31:0] b,
                                        logic [31:0] num, logic [31:0] dt);
      logic [97:0] va, vb, diff, mag, q;
      bit neg;
      va = {{66{a[31]}}, a};
      vb = {{66{b[31]}}, b};
      diff = vb - va;
      neg = diff[97];
      mag = neg ? -diff : diff;
      q = (mag * {66'd0, num} + {66'd0, dt} / 2) / {66'd0, dt};
      return 32'(neg ? (va - q) : (va + q));
   endfunction

   function automatic void add_snapshot(int s);
      tsi_pkg::rsp_type e;
      for (int i = 0; i < ENT; i++) begin
         e = '{1'b1, snap_tick[s], snap_x[s][i], snap_y[s][i], snap_flag[s][i],
               snap_aux[s][i], i == ENT - 1};
         add_answer(e);
      end
   endfunction

   function automatic void predict(tsi_pkg::req_type r);
      int lim, s, hi, sa, sb;
      logic [31:0] num, dt;
      tsi_pkg::rsp_type e;
      if (r.opcode == tsi_pkg::KIND_QUERY) begin
         n_queries++;
         if (count == 0) begin
            add_answer('{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 16'd0, 1'b1});
            return;
         end
         if (r.tick <= snap_tick[slot(0)]) begin
            add_snapshot(slot(0));
            return;
         end
         if (r.tick >= snap_tick[slot(count - 1)]) begin
            add_snapshot(slot(count - 1));
            return;
         end
         hi = 1;
         while (hi < count && snap_tick[slot(hi)] < r.tick) hi++;
         sa = slot(hi - 1);
         sb = slot(hi);
         dt = snap_tick[sb] - snap_tick[sa];
         num = r.tick - snap_tick[sa];
         n_interp++;
         for (int i = 0; i < ENT; i++) begin
            e = '{1'b1, r.tick, lerp(snap_x[sa][i], snap_x[sb][i], num, dt),
                  lerp(snap_y[sa][i], snap_y[sb][i], num, dt),
                  snap_flag[sa][i] & snap_flag[sb][i], snap_aux[sa][i], i == ENT - 1};
            add_answer(e);
         end
         return;
      end
      n_loads++;
      if (load_idx == 0) begin
         for (int i = 0; i < ENT; i++) begin
            stg_x[i] = 0; stg_y[i] = 0; stg_flag[i] = 0; stg_aux[i] = 0;
         end
         stg_tick = r.tick;
         discarding = count > 0 && r.tick <= newest_tick();
      end
      stg_x[load_idx] = r.pos_x;
      stg_y[load_idx] = r.pos_y;
      stg_flag[load_idx] = r.active;
      stg_aux[load_idx] = r.aux_value;
      if (r.last_entity || load_idx + 1 >= ENT) begin
         if (!discarding) begin
            lim = lim_reg < 1 ? 1 : (lim_reg > DEPTH ? DEPTH : lim_reg);
            while (count >= lim && count > 0) begin
               oldest = (oldest + 1) % DEPTH;
               count--;
            end
            s = slot(count);
            snap_tick[s] = stg_tick;
            for (int i = 0; i < ENT; i++) begin
               snap_x[s][i] = stg_x[i]; snap_y[s][i] = stg_y[i];
               snap_flag[s][i] = stg_flag[i]; snap_aux[s][i] = stg_aux[i];
            end
            count++;
            n_commits++;
         end
         load_idx = 0;
         discarding = 0;
      end else begin
         load_idx++;
      end
   endfunction

   task automatic send(tsi_pkg::req_type r, bit typed = 0, tsi_pkg::rsp_type e = '0);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      if (typed) begin
         n_queries++;
         add_answer(e);
      end else begin
         predict(r);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_limit(logic [3:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      lim_reg = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic tsi_pkg::req_type rec(logic [31:0] t, bit last);
      tsi_pkg::req_type r;
      r.opcode = tsi_pkg::KIND_LOAD;
      r.tick = t;
      r.pos_x = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000) - 1000;
      r.pos_y = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000) - 1000;
      r.active = 1'($urandom_range(0, 1));
      r.aux_value = 16'($urandom);
      r.last_entity = last;
      return r;
   endfunction

   function automatic tsi_pkg::req_type query_at(logic [31:0] t);
      tsi_pkg::req_type r;
      r = '0;
      r.opcode = tsi_pkg::KIND_QUERY;
      r.tick = t;
      return r;
   endfunction

   task automatic send_snapshot(logic [31:0] t);
      int n;
      bit full;
      full = $urandom_range(0, 3) == 0;
      n = full ? ENT : $urandom_range(1, ENT);
      for (int i = 0; i < n; i++) send(rec(i == 0 ? t : $urandom, !full && i == n - 1));
   endtask

   function automatic logic [31:0] pick_query();
      logic [31:0] lo, top;
      if (count == 0) return $urandom;
      lo = snap_tick[slot(0)];
      top = newest_tick();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return lo - $urandom_range(0, 5);
         2: return top + $urandom_range(0, 5);
         3: return snap_tick[slot($urandom_range(0, count - 1))];
         default: return lo + ((top - lo) == 0 ? 0 : $urandom_range(0, top - lo));
      endcase
   endfunction

   task automatic random_phase(int items, bit pause_once);
      int start;
      logic [31:0] t;
      start = n_loads + n_queries;
      while (n_loads + n_queries - start < items) begin
         if ($urandom_range(0, 2) == 0) begin
            if (pause_once) begin
               drain();
               pause_once = 0;
            end
            send(query_at(pick_query()));
         end else begin
            if (count > 0 && $urandom_range(0, 7) == 0)
               t = newest_tick() - $urandom_range(0, 20);
            else if ($urandom_range(0, 9) == 0)
               t = newest_tick() + $urandom_range(1, 1 << 24);
            else
               t = newest_tick() + $urandom_range(1, 1000);
            send_snapshot(t);
         end
      end
   endtask

   stim_row_type table_rows [14];
   logic [3:0] limits[] = '{4'd1, 4'd3, 4'd15, 4'd0, 4'd5, 4'd2, 4'd8};

   function automatic tsi_pkg::req_type ld(logic [31:0] t, logic [31:0] x, logic [31:0] y,
                                           bit a, logic [15:0] aux, bit last);
      return '{tsi_pkg::KIND_LOAD, t, x, y, a, aux, last};
   endfunction

   initial begin
      stim_row_type row;
      reset = 1; req_valid = 0; req_data = '0; rsp_stall = 0;
      csr_valid = 0; csr_data = '0;
      lim_reg = tsi_pkg::LIMIT_RESET; oldest = 0; count = 0; load_idx = 0; discarding = 0;
      errors = 0; cycles = 0; idle_on = 1; stall_left = 0;
      exp_wr = 0; exp_rd = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      table_rows[0]  = '{query_at(32'd5), 1,
                         '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 16'd0, 1'b1}};
      table_rows[1]  = '{ld(100, 32'h7fffffff, 32'h80000000, 1, 16'hffff, 0), 0, '0};
      table_rows[2]  = '{ld(7, 32'h80000000, 32'h7fffffff, 0, 16'h0000, 1), 0, '0};
      table_rows[3]  = '{query_at(100), 0, '0};
      table_rows[4]  = '{ld(50, 32'h1, 32'h2, 1, 16'h3, 1), 0, '0};
      table_rows[5]  = '{ld(100, 32'h1, 32'h2, 1, 16'h3, 1), 0, '0};
      table_rows[6]  = '{ld(300, 32'h80000000, 32'h7fffffff, 1, 16'h1234, 0), 0, '0};
      table_rows[7]  = '{ld(0, 32'h7fffffff, 32'h80000000, 1, 16'hffff, 1), 0, '0};
      table_rows[8]  = '{query_at(0), 0, '0};
      table_rows[9]  = '{query_at(200), 0, '0};
      table_rows[10] = '{query_at(101), 0, '0};
      table_rows[11] = '{query_at(299), 0, '0};
      table_rows[12] = '{query_at(300), 0, '0};
      table_rows[13] = '{query_at(32'hffffffff), 0, '0};
      foreach (table_rows[i]) begin
         row = table_rows[i];
         send(row.r, row.typed, row.e);
      end
      drain();

      foreach (limits[i]) begin
         write_limit(limits[i]);
         random_phase(44, i == 2);
         drain();
      end

      idle_on = 0;
      send_snapshot(32'h80000000 + $urandom_range(0, 1000));
      send_snapshot(32'hffffffff);
      send(query_at(32'hc0000000));
      send(query_at(32'hffffffff));
      random_phase(20, 0);
      drain();

      $display("covered %0d loads, %0d queries (%0d interpolated), %0d commits, %0d results",
               n_loads, n_queries, n_interp, n_commits, n_results);
      $display("history limits exercised from 0 to 15, with eviction and stale drops");
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
